FILE: hdl/normal_cdf_approximation_assert.svh
// ----------------------------------------------------------------------------
// Normal CDF approximation assertion macros
// Short forms for the concurrent checks used on the block's stream ports.
// ----------------------------------------------------------------------------
`ifndef NORMAL_CDF_APPROXIMATION_ASSERT_SVH
`define NORMAL_CDF_APPROXIMATION_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define NCDF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ncdf check failed");

// Next-cycle implication, ignored while reset is high.
`define NCDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ncdf check failed");

// Next-cycle implication that is also checked across reset.
`define NCDF_ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("ncdf check failed");

`endif

FILE: hdl/ncdf_pkg.sv
// ----------------------------------------------------------------------------
// Normal CDF package
// Fixed-point constants, widths and stage counts shared by the CDF pipeline.
// ----------------------------------------------------------------------------
package ncdf_pkg;

   // Q.30 constants, rounded to nearest at elaboration.
   localparam logic [63:0] K_ONE = 64'd1 << 30;
   localparam logic [63:0] K_A1 = ((64'd254829592 << 30) + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] K_A2 = ((64'd284496736 << 30) + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] K_A3 = ((64'd1421413741 << 30) + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] K_A4 = ((64'd1453152027 << 30) + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] K_A5 = ((64'd1061405429 << 30) + 64'd500000000) / 64'd1000000000;
   localparam logic [63:0] K_P = ((64'd3275911 << 30) + 64'd5000000) / 64'd10000000;
   localparam logic [63:0] K_RS2 = ((64'd7071067812 << 30) + 64'd5000000000) / 64'd10000000000;
   localparam logic [63:0] K_LN2 = ((64'd6931471806 << 30) + 64'd5000000000) / 64'd10000000000;

   // Datapath widths.
   localparam int MAG_W = 16;   // |x| in Q4.12
   localparam int Z_W = 33;     // z in Q.30
   localparam int D_W = 32;     // 1 + p*z in Q.30
   localparam int T_W = 31;     // t in Q.30, at most 1.0
   localparam int PW = 34;      // signed Horner accumulator
   localparam int W_W = 37;     // z*z in Q.30
   localparam int K_W = 6;      // integer part of w/ln2
   localparam int R_W = 30;     // reduced argument, below ln2
   localparam int E_W = 31;     // exp(-w) in Q.30
   localparam int TERMS = 14;   // Taylor terms of exp(-r)

   // Stage counts of the pipeline sections.
   localparam int DIV_LAT = T_W;
   localparam int HORN_LAT = 10;
   localparam int EXP_LAT = K_W + 3 * TERMS + 1;
   localparam int QDLY = EXP_LAT - DIV_LAT - HORN_LAT;
   localparam int PRE_LAT = 4;
   localparam int TOTAL_LAT = PRE_LAT + EXP_LAT + 2;

endpackage

FILE: hdl/ncdf_div.sv
// ----------------------------------------------------------------------------
// Normal CDF reciprocal
// Pipelined restoring divider giving t = round(2^60 / d), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module ncdf_div
   import ncdf_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [D_W-1:0] d_value,
   output logic [T_W-1:0] t_value
);

   logic [D_W-1:0] rem_ff [DIV_LAT];
   logic [D_W-1:0] dd_ff [DIV_LAT];
   logic [T_W-1:0] low_ff [DIV_LAT];
   logic [T_W-1:0] q_ff [DIV_LAT];

   // The dividend is 2^60 + d/2: its upper part is 2^29, its lower 31 bits d/2.
   genvar s;
   generate
      for (s = 0; s < DIV_LAT; s++) begin : g_stage
         logic [D_W-1:0] rem_prev;
         logic [D_W-1:0] d_prev;
         logic [T_W-1:0] low_prev;
         logic [T_W-1:0] q_prev;
         logic [D_W:0]   trial;
         logic           take;

         if (s == 0) begin : g_first
            assign rem_prev = D_W'(1) << 29;
            assign d_prev = d_value;
            assign low_prev = T_W'(d_value >> 1);
            assign q_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[s-1];
            assign d_prev = dd_ff[s-1];
            assign low_prev = low_ff[s-1];
            assign q_prev = q_ff[s-1];
         end

         assign trial = {rem_prev, low_prev[T_W-1-s]};
         assign take = trial >= {1'b0, d_prev};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= take ? D_W'(trial - {1'b0, d_prev}) : D_W'(trial);
               dd_ff[s] <= d_prev;
               low_ff[s] <= low_prev;
               q_ff[s] <= q_prev | (T_W'(take) << (T_W - 1 - s));
            end
         end
      end
   endgenerate

   assign t_value = q_ff[DIV_LAT-1];

endmodule

FILE: hdl/ncdf_exp.sv
// ----------------------------------------------------------------------------
// Normal CDF exponential
// Pipelined exp(-w): range reduction by ln2, a 14-term Taylor series of
// exp(-r) in three stages per term, and a rounded shift by k.
// ----------------------------------------------------------------------------
module ncdf_exp
   import ncdf_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [W_W-1:0] w_value,
   output logic [E_W-1:0] e_value
);

   typedef struct packed {
      logic [R_W-1:0] r;
      logic [K_W-1:0] k;
      logic [31:0]    acc;
   } exp_ctx_type;

   logic [W_W-1:0] krem_ff [K_W];
   logic [K_W-1:0] kq_ff [K_W];

   // Range reduction: one quotient bit of w / ln2 per stage.
   genvar s;
   generate
      for (s = 0; s < K_W; s++) begin : g_kdiv
         logic [W_W-1:0] rem_prev;
         logic [K_W-1:0] k_prev;
         logic [W_W-1:0] step;
         logic           take;

         if (s == 0) begin : g_first
            assign rem_prev = w_value;
            assign k_prev = '0;
         end else begin : g_next
            assign rem_prev = krem_ff[s-1];
            assign k_prev = kq_ff[s-1];
         end

         assign step = W_W'(K_LN2) << (K_W - 1 - s);
         assign take = rem_prev >= step;

         always_ff @(posedge clock) begin
            if (en) begin
               krem_ff[s] <= take ? rem_prev - step : rem_prev;
               kq_ff[s] <= {k_prev[K_W-2:0], take};
            end
         end
      end
   endgenerate

   exp_ctx_type    ctxa_ff [1:TERMS];
   exp_ctx_type    ctxb_ff [1:TERMS];
   exp_ctx_type    ctxc_ff [1:TERMS];
   logic [63:0]    proda_ff [1:TERMS];
   logic [T_W-1:0] xb_ff [1:TERMS];
   logic [63:0]    prodb_ff [1:TERMS];
   logic [T_W-1:0] termc_ff [1:TERMS];

   // Each term is round(round(prev * r) / n); odd terms subtract.
   genvar n;
   generate
      for (n = 1; n <= TERMS; n++) begin : g_term
         localparam logic [31:0] RECIP = 32'((64'd1 << 31) / n);
         localparam logic [T_W-1:0] HALF_N = T_W'(n / 2);
         logic [T_W-1:0] term_prev;
         exp_ctx_type    ctx_prev;
         logic [T_W-1:0] rounded;
         logic [T_W-1:0] qhat;
         logic [T_W-1:0] rem;
         logic [T_W-1:0] term;

         if (n == 1) begin : g_first
            assign term_prev = T_W'(K_ONE);
            assign ctx_prev = '{r: R_W'(krem_ff[K_W-1]), k: kq_ff[K_W-1],
                                acc: 32'(K_ONE)};
         end else begin : g_next
            assign term_prev = termc_ff[n-1];
            assign ctx_prev = ctxc_ff[n-1];
         end

         assign rounded = T_W'((proda_ff[n] + 64'd536870912) >> 30);
         assign qhat = T_W'(prodb_ff[n] >> 31);
         assign rem = xb_ff[n] - T_W'(qhat * T_W'(n));
         assign term = (rem >= T_W'(n)) ? qhat + T_W'(1) : qhat;

         always_ff @(posedge clock) begin
            if (en) begin
               proda_ff[n] <= 64'(term_prev) * 64'(ctx_prev.r);
               ctxa_ff[n] <= ctx_prev;
               xb_ff[n] <= rounded + HALF_N;
               prodb_ff[n] <= 64'(rounded + HALF_N) * 64'(RECIP);
               ctxb_ff[n] <= ctxa_ff[n];
               termc_ff[n] <= term;
               ctxc_ff[n] <= '{r: ctxb_ff[n].r, k: ctxb_ff[n].k,
                               acc: (n % 2 == 1) ? ctxb_ff[n].acc - 32'(term)
                                                 : ctxb_ff[n].acc + 32'(term)};
            end
         end
      end
   endgenerate

   logic [31:0]    shift_bias;
   logic [31:0]    shifted;
   logic [E_W-1:0] e_ff;

   assign shift_bias = (32'd1 << ctxc_ff[TERMS].k[4:0]) >> 1;
   assign shifted = (ctxc_ff[TERMS].acc + shift_bias) >> ctxc_ff[TERMS].k[4:0];

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= (ctxc_ff[TERMS].k >= K_W'(31)) ? '0 : E_W'(shifted);
      end
   end

   assign e_value = e_ff;

endmodule

FILE: hdl/normal_cdf_approximation.sv
// ----------------------------------------------------------------------------
// Normal CDF approximation
// Streaming evaluator of the standard normal CDF by the classic erf
// rational-times-exponential approximation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// The block takes one sample per beat on the req_ channel: a signed Q4.12
// argument in req_tdata. Each sample yields exactly one beat on the rsp_
// channel holding Phi(x) as unsigned Q0.16, saturated at 65535.
// The block holds no state between samples, so beats are independent.
// Throughput is one beat per cycle whenever the receiver takes responses;
// the depth is set by the 31-stage reciprocal divider in parallel with the
// 49-stage exponential (range reduction, three stages per Taylor term,
// final shift), plus four front stages and two back stages.
// The whole pipeline advances together: when a response waits and
// rsp_tready is low, every stage holds and req_tready drops, so nothing is
// lost or repeated. Bubbles travel as cleared valid bits.
// Synchronous reset clears all valid bits; no response is shown after reset
// until a new request beat has traveled the pipeline.
// ----------------------------------------------------------------------------
module normal_cdf_approximation
   import ncdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] x_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] probability
);

   // All stages move together whenever the output stage is free or drained.
   logic en;
   logic [TOTAL_LAT:1] vld_ff;

   assign en = !vld_ff[TOTAL_LAT] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-1:1], req_tvalid};
      end
   end

   // The sign rides along a shift line until the final stage.
   logic neg_ff [1:TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[1] <= req_tdata[15];
         for (int i = 2; i < TOTAL_LAT; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   // Front stages: magnitude, z = |x|/sqrt(2), then d = 1 + p*z and w = z*z.
   logic [MAG_W-1:0] mag_ff;
   logic [Z_W-1:0]   z_ff;
   logic [63:0]      pz_ff;
   logic [35:0]      zhh_ff;
   logic [32:0]      zhl_ff;
   logic [29:0]      zll_ff;
   logic [D_W-1:0]   d_ff;
   logic [W_W-1:0]   w_ff;
   logic [17:0]      zh;
   logic [14:0]      zl;

   assign zh = z_ff[Z_W-1:15];
   assign zl = z_ff[14:0];

   always_ff @(posedge clock) begin
      if (en) begin
         // The most negative input maps to a magnitude of 8.0.
         mag_ff <= req_tdata[15] ? MAG_W'(~req_tdata + 16'd1) : req_tdata;
         z_ff <= Z_W'((48'(mag_ff) * 48'(K_RS2) + 48'd2048) >> 12);
         pz_ff <= 64'(z_ff) * 64'(K_P);
         zhh_ff <= 36'(zh) * 36'(zh);
         zhl_ff <= 33'(zh) * 33'(zl);
         zll_ff <= 30'(zl) * 30'(zl);
         d_ff <= D_W'(K_ONE + ((pz_ff + 64'd536870912) >> 30));
         w_ff <= W_W'(zhh_ff) + W_W'((36'(zhl_ff) * 36'd2 + 36'(zll_ff >> 15)
                                      + 36'd16384) >> 15);
      end
   end

   // Reciprocal t and exponential run side by side.
   logic [T_W-1:0] t_value;
   logic [E_W-1:0] e_value;

   ncdf_div u_div (
      .clock   (clock),
      .en      (en),
      .d_value (d_ff),
      .t_value (t_value)
   );

   ncdf_exp u_exp (
      .clock   (clock),
      .en      (en),
      .w_value (w_ff),
      .e_value (e_value)
   );

   // Horner evaluation: each step is a multiply stage and a round-and-add
   // stage. Products round to nearest with ties away from zero.
   logic           ha_neg_ff [5];
   logic [63:0]    ha_prod_ff [5];
   logic [T_W-1:0] ha_t_ff [5];
   logic signed [PW-1:0] hb_poly_ff [5];
   logic [T_W-1:0] hb_t_ff [5];

   genvar h;
   generate
      for (h = 0; h < 5; h++) begin : g_horner
         localparam logic signed [PW-1:0] ADD_TERM =
            (h == 0) ? -$signed(PW'(K_A4)) :
            (h == 1) ?  $signed(PW'(K_A3)) :
            (h == 2) ? -$signed(PW'(K_A2)) :
            (h == 3) ?  $signed(PW'(K_A1)) : '0;
         logic signed [PW-1:0] poly_prev;
         logic [T_W-1:0]       t_prev;
         logic [PW-2:0]        mag_prev;
         logic [PW-1:0]        rnd;
         logic signed [PW-1:0] signed_rnd;

         if (h == 0) begin : g_first
            assign poly_prev = $signed(PW'(K_A5));
            assign t_prev = t_value;
         end else begin : g_next
            assign poly_prev = hb_poly_ff[h-1];
            assign t_prev = hb_t_ff[h-1];
         end

         assign mag_prev = poly_prev[PW-1] ? (PW-1)'(-poly_prev) : (PW-1)'(poly_prev);
         assign rnd = PW'((ha_prod_ff[h] + 64'd536870912) >> 30);
         assign signed_rnd = ha_neg_ff[h] ? -$signed(rnd) : $signed(rnd);

         always_ff @(posedge clock) begin
            if (en) begin
               ha_neg_ff[h] <= poly_prev[PW-1];
               ha_prod_ff[h] <= 64'(mag_prev) * 64'(t_prev);
               ha_t_ff[h] <= t_prev;
               hb_poly_ff[h] <= signed_rnd + ADD_TERM;
               hb_t_ff[h] <= ha_t_ff[h];
            end
         end
      end
   endgenerate

   // Clamp q to [0, 1.0], then delay it to meet the exponential.
   logic [T_W-1:0] q_clamped;
   logic [T_W-1:0] qd_ff [1:QDLY];

   always_comb begin
      priority if (hb_poly_ff[4][PW-1]) begin
         q_clamped = '0;
      end else if (hb_poly_ff[4] > $signed(PW'(K_ONE))) begin
         q_clamped = T_W'(K_ONE);
      end else begin
         q_clamped = T_W'(hb_poly_ff[4]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qd_ff[1] <= q_clamped;
         for (int i = 2; i <= QDLY; i++) begin
            qd_ff[i] <= qd_ff[i-1];
         end
      end
   end

   // Back stages: prod = q * exp(-z^2), then fold in the sign and round.
   logic [63:0] prodm_ff;
   logic [31:0] prod;
   logic [31:0] res;
   logic [16:0] res_rnd;
   logic [15:0] prob_ff;

   assign prod = 32'((prodm_ff + 64'd536870912) >> 30);
   assign res = neg_ff[TOTAL_LAT-1] ? prod : 32'h8000_0000 - prod;
   assign res_rnd = 17'((33'(res) + 33'd16384) >> 15);

   always_ff @(posedge clock) begin
      if (en) begin
         prodm_ff <= 64'(qd_ff[QDLY]) * 64'(e_value);
         prob_ff <= res_rnd[16] ? 16'hFFFF : res_rnd[15:0];
      end
   end

   assign rsp_tvalid = vld_ff[TOTAL_LAT];
   assign rsp_tdata = prob_ff;

endmodule

FILE: hdl/ncdf_checker.sv
// ----------------------------------------------------------------------------
// Normal CDF port checker
// Watches the stream ports of the CDF block over time.
// ----------------------------------------------------------------------------
`include "normal_cdf_approximation_assert.svh"

module ncdf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A waiting response beat stays and keeps its data.
   `NCDF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `NCDF_ASSERT_NEXT(a_rsp_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // The pipeline takes requests whenever its output stage is empty.
   `NCDF_ASSERT_SAME(a_req_open, clock, reset, !rsp_tvalid, req_tready)
   // Reset leaves no response on the bus.
   `NCDF_ASSERT_NEXT_RAW(a_rst_empty, clock, reset, !rsp_tvalid)

endmodule

bind normal_cdf_approximation ncdf_checker u_ncdf_checker (.*);
